FILE: design/infsf_pkg.sv
`default_nettype none

package infsf_pkg;

  // Depth of the job queue between the front and back parts (power of two).
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAddrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One accepted item after classification, as the back part consumes it.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       ctrl;
    logic [7:0] bcc;
  } job_t;

  // Framing configuration as the back part sees it.
  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] mask;
    logic [7:0] address;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/infsf_front.sv
`default_nettype none

module infsf_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              accept_i,
  input  wire [7:0]        data_byte_i,
  input  wire              first_byte_i,
  input  wire              last_byte_i,
  input  wire              seq_number_i,
  output infsf_pkg::job_t  job_o
);

  logic [7:0] running_check_q, running_check_d;
  logic [7:0] check_sum;

  // A first byte restarts the check; the sum including this byte becomes BCC2.
  assign check_sum = (first_byte_i ? 8'h00 : running_check_q) ^ data_byte_i;

  always_comb begin
    running_check_d = running_check_q;
    if (accept_i) begin
      running_check_d = last_byte_i ? 8'h00 : check_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_check_q <= 8'h00;
    end else begin
      running_check_q <= running_check_d;
    end
  end

  always_comb begin
    job_o.data  = data_byte_i;
    job_o.first = first_byte_i;
    job_o.last  = last_byte_i;
    job_o.ctrl  = seq_number_i;
    job_o.bcc   = check_sum;
  end

endmodule

`default_nettype wire

FILE: design/infsf_queue.sv
`default_nettype none

module infsf_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              wr_i,
  input  infsf_pkg::job_t  wr_job_i,
  output logic             full_o,
  input  wire              rd_i,
  output infsf_pkg::job_t  rd_job_o,
  output logic             valid_o
);

  localparam int unsigned AW = infsf_pkg::QAddrW;
  localparam int unsigned CW = infsf_pkg::QCntW;

  infsf_pkg::job_t mem_q [infsf_pkg::QDepth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(infsf_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + AW'(1);
      if (do_rd) rd_ptr_q <= rd_ptr_q + AW'(1);
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/infsf_back.sv
`default_nettype none

module infsf_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  infsf_pkg::cfg_t  cfg_i,
  input  infsf_pkg::job_t  head_i,
  input  wire              head_valid_i,
  output logic             head_pop_o,
  output logic [7:0]       out_byte_o,
  output logic             frame_end_o,
  output logic             empty_o,
  input  wire              pop_i
);

  localparam logic [3:0] P_START  = 4'd0;
  localparam logic [3:0] P_HFLAG  = 4'd1;
  localparam logic [3:0] P_ADDR   = 4'd2;
  localparam logic [3:0] P_CTRL   = 4'd3;
  localparam logic [3:0] P_BCC1   = 4'd4;
  localparam logic [3:0] P_DATA   = 4'd5;
  localparam logic [3:0] P_DATA_X = 4'd6;
  localparam logic [3:0] P_BCC    = 4'd7;
  localparam logic [3:0] P_BCC_X  = 4'd8;
  localparam logic [3:0] P_TAIL   = 4'd9;

  logic [3:0] phase_q, phase_d, cur, nxt;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       frame_end_q, frame_end_d;
  logic       load_ok, go, done;
  logic [7:0] emit_byte;
  logic       emit_end;
  logic [7:0] ctrl_byte;
  logic       data_stuff, bcc_stuff;

  assign load_ok    = !out_valid_q || pop_i;
  assign go         = head_valid_i && load_ok;
  assign ctrl_byte  = {7'b0, head_i.ctrl};
  assign data_stuff = (head_i.data == cfg_i.flag) || (head_i.data == cfg_i.escape);
  assign bcc_stuff  = (head_i.bcc == cfg_i.flag) || (head_i.bcc == cfg_i.escape);

  // At the start of a job the first step depends on whether a header is due.
  assign cur = (phase_q == P_START) ? (head_i.first ? P_HFLAG : P_DATA) : phase_q;

  always_comb begin
    emit_byte = head_i.data;
    emit_end  = 1'b0;
    nxt       = P_START;
    done      = 1'b0;
    unique case (cur)
      P_HFLAG: begin
        emit_byte = cfg_i.flag;
        nxt       = P_ADDR;
      end
      P_ADDR: begin
        emit_byte = cfg_i.address;
        nxt       = P_CTRL;
      end
      P_CTRL: begin
        emit_byte = ctrl_byte;
        nxt       = P_BCC1;
      end
      P_BCC1: begin
        emit_byte = cfg_i.address ^ ctrl_byte;
        nxt       = P_DATA;
      end
      P_DATA: begin
        if (data_stuff) begin
          emit_byte = cfg_i.escape;
          nxt       = P_DATA_X;
        end else begin
          emit_byte = head_i.data;
          nxt       = P_BCC;
          done      = !head_i.last;
        end
      end
      P_DATA_X: begin
        emit_byte = head_i.data ^ cfg_i.mask;
        nxt       = P_BCC;
        done      = !head_i.last;
      end
      P_BCC: begin
        if (bcc_stuff) begin
          emit_byte = cfg_i.escape;
          nxt       = P_BCC_X;
        end else begin
          emit_byte = head_i.bcc;
          nxt       = P_TAIL;
        end
      end
      P_BCC_X: begin
        emit_byte = head_i.bcc ^ cfg_i.mask;
        nxt       = P_TAIL;
      end
      P_TAIL: begin
        emit_byte = cfg_i.flag;
        emit_end  = 1'b1;
        done      = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    frame_end_d = frame_end_q;
    head_pop_o  = 1'b0;
    if (go) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      frame_end_d = emit_end;
      phase_d     = done ? P_START : nxt;
      head_pop_o  = done;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= P_START;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    frame_end_q <= frame_end_d;
  end

  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;
  assign empty_o     = !out_valid_q;

  // A job in progress always has its entry at the head of the queue.
  a_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != P_START) |-> head_valid_i)
    else $error("back part is mid-job without a queued entry");

  // The head entry is released only together with a byte going out.
  a_pop_with_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop_o |-> (go && out_valid_d))
    else $error("queue entry released without emitting a byte");

  // The closing flag is marked as the end of the frame.
  a_tail_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && (cur == P_TAIL)) |=> (out_valid_q && frame_end_q))
    else $error("closing flag went out without frame end");

  // The second byte of an escape pair follows the escape byte directly.
  a_escape_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == P_DATA_X || phase_q == P_BCC_X) |-> (out_valid_q && !frame_end_q))
    else $error("escaped byte pending without its escape byte");

endmodule

`default_nettype wire

FILE: design/info_frame_stuffing_framer_unit.sv
`default_nettype none

// Information frame framer with byte stuffing and XOR block checks. Payload
// items enter through a queue-style port (push/full) and the framed byte stream
// leaves through another (empty/pop), one output byte per cycle while a job is
// queued and the output is popped. A front part keeps the running XOR of the
// payload and hands each item to a two-entry job queue; a back part walks each
// job through header (first item only), stuffed data and, for a last item,
// stuffed BCC2 and closing flag. An item leaves the job queue with the last
// output byte it produces, one for a plain middle byte, two for an escaped
// one and up to nine for a single-byte packet. Input items are taken every
// cycle while the job queue has room. The four framing registers sit on the
// APB port at byte addresses 0, 4, 8 and 12 and should be changed only while
// the block is idle.
module info_frame_stuffing_framer_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  data_byte_i,
  input  wire         first_byte_i,
  input  wire         last_byte_i,
  input  wire         seq_number_i,
  output logic        empty,
  input  wire         pop,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_FLAG    = 2'd0;
  localparam logic [1:0] REG_ESCAPE  = 2'd1;
  localparam logic [1:0] REG_MASK    = 2'd2;
  localparam logic [1:0] REG_ADDRESS = 2'd3;

  infsf_pkg::cfg_t cfg_q;
  infsf_pkg::job_t front_job, head_job;
  logic            accept, head_valid, head_pop, cfg_wr;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag    <= 8'h7E;
      cfg_q.escape  <= 8'h7D;
      cfg_q.mask    <= 8'h20;
      cfg_q.address <= 8'h03;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FLAG:    cfg_q.flag    <= pwdata[7:0];
        REG_ESCAPE:  cfg_q.escape  <= pwdata[7:0];
        REG_MASK:    cfg_q.mask    <= pwdata[7:0];
        REG_ADDRESS: cfg_q.address <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FLAG:    prdata = {24'b0, cfg_q.flag};
      REG_ESCAPE:  prdata = {24'b0, cfg_q.escape};
      REG_MASK:    prdata = {24'b0, cfg_q.mask};
      REG_ADDRESS: prdata = {24'b0, cfg_q.address};
      default:     prdata = '0;
    endcase
  end

  assign accept = push && !full;

  infsf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .seq_number_i (seq_number_i),
    .job_o        (front_job)
  );

  infsf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push),
    .wr_job_i (front_job),
    .full_o   (full),
    .rd_i     (head_pop),
    .rd_job_o (head_job),
    .valid_o  (head_valid)
  );

  infsf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head_job),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .out_byte_o   (out_byte_o),
    .frame_end_o  (frame_end_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule

`default_nettype wire
